// ===== hdl/dtsc_pkg.sv =====
// shared types and constants of the dense-to-sparse coordinate scan
`timescale 1ns / 1ps
package dtsc_pkg;

	localparam int EXT_W     = 9;
	localparam int COORD_W   = 8;
	localparam int VAL_W     = 64;
	localparam int CNT_W     = 13;
	localparam int IDX_W     = 12;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = 4 * EXT_W;
	localparam int SETTLE_W  = 3;

	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_REWIND = 2'd1;
	localparam logic [OP_W-1:0] OP_NEXT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_EXTENT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_EXTENT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THIRD_EXTENT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOURTH_EXTENT = 2'd3;

	// cycles from an extent write until the size check is valid
	localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd4;

	typedef struct packed {
		logic wr_en;
		logic rewind;
		logic t1_ld;
		logic t2_ld;
		logic addr_ld;
		logic rd_en;
		logic adv;
		logic emit_found;
		logic emit_done;
		logic emit_err;
		logic out_ld;
	} dtsc_cmd_t;

	typedef struct packed {
		logic stable;
		logic size_err;
		logic finished;
		logic first_out;
		logic in_range;
		logic nonzero;
		logic out_free;
	} dtsc_sts_t;

	typedef struct packed {
		logic               size_error;
		logic               scan_done;
		logic [CNT_W-1:0]   entry_number;
		logic [VAL_W-1:0]   found_value;
		logic [COORD_W-1:0] fourth_coord;
		logic [COORD_W-1:0] third_coord;
		logic [COORD_W-1:0] second_coord;
		logic [COORD_W-1:0] first_coord;
	} dtsc_res_t;

endpackage

// ===== hdl/dense_to_sparse_coordinate_scan_core.sv =====
// top level of the dense-to-sparse coordinate scan
// write and rewind items return nothing
// a fetch is accepted, checked once the size check settles, then walks the array to its end
// or a nonzero element: in-range positions pass the step, address, read and test states,
// out-of-range ones are skipped, and the output load waits while the previous result is held
// reset clears control, cursors and count and sets all extents to 1; store contents stay
// undefined until written, there is no clearing pass
`timescale 1ns / 1ps
module dense_to_sparse_coordinate_scan_core #(
	parameter int unsigned STORE_DEPTH = 4096,
	parameter int unsigned EXTENT_MAX  = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [79:0]                        s_tdata,   // element_index, element_value, pad
	input  logic [dtsc_pkg::OP_W-1:0]          s_tuser,   // opcode
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// first_coord, second_coord, third_coord, fourth_coord, found_value, entry_number, pad
	output logic [111:0]                       m_tdata,
	output logic [1:0]                         m_tuser,   // scan_done, size_error
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dtsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dtsc_pkg::EXT_W-1:0]         cfg_data
);

	dtsc_pkg::dtsc_cmd_t cmd;
	dtsc_pkg::dtsc_sts_t sts;
	dtsc_pkg::dtsc_res_t res;

	assign cfg_ready = 1'b1;

	dtsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtsc_dpath #(
		.STORE_DEPTH (STORE_DEPTH),
		.EXTENT_MAX  (EXTENT_MAX)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_index  (s_tdata[11:0]),
		.in_value  (s_tdata[75:12]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.res       (res),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign m_tdata = {3'b000, res.entry_number, res.found_value, res.fourth_coord,
	                  res.third_coord, res.second_coord, res.first_coord};
	assign m_tuser = {res.size_error, res.scan_done};

	// a new result is never loaded over one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// error result carries nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]))
		else $error("size error result not clean");

	// done result has zero coordinates and value
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[95:0] == '0))
		else $error("done result has data");

	// found item is never a signed zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0] && !m_tuser[1]) |-> (m_tdata[94:32] != '0))
		else $error("zero element reported as found");

endmodule

// ===== hdl/dtsc_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module dtsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/dtsc_ctrl.sv =====
// scan controller: sequences writes, rewinds and the element walk of a fetch
`timescale 1ns / 1ps
module dtsc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [dtsc_pkg::OP_W-1:0]  in_op,
	output logic                       in_ready,
	input  dtsc_pkg::dtsc_sts_t        sts,
	output dtsc_pkg::dtsc_cmd_t        cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CHECK = 8'b0000_0010,
		S_STEP  = 8'b0000_0100,
		S_ADDR2 = 8'b0000_1000,
		S_ADDR3 = 8'b0001_0000,
		S_READ  = 8'b0010_0000,
		S_TEST  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == dtsc_pkg::OP_WRITE) begin
						cmd.wr_en = 1'b1;
					end else if (in_op == dtsc_pkg::OP_REWIND) begin
						cmd.rewind = 1'b1;
					end else if (in_op == dtsc_pkg::OP_NEXT) begin
						state_nxt = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				// wait for the extent product to settle after a config write
				if (sts.stable) begin
					if (sts.size_err) begin
						cmd.emit_err = 1'b1;
						state_nxt    = S_EMIT;
					end else if (sts.finished) begin
						cmd.emit_done = 1'b1;
						state_nxt     = S_EMIT;
					end else begin
						state_nxt = S_STEP;
					end
				end
			end
			S_STEP: begin
				if (sts.first_out) begin
					cmd.emit_done = 1'b1;
					state_nxt     = S_EMIT;
				end else if (sts.in_range) begin
					cmd.t1_ld = 1'b1;
					state_nxt = S_ADDR2;
				end else begin
					// position outside the extents, skip it
					cmd.adv = 1'b1;
				end
			end
			S_ADDR2: begin
				cmd.t2_ld = 1'b1;
				state_nxt = S_ADDR3;
			end
			S_ADDR3: begin
				cmd.addr_ld = 1'b1;
				state_nxt   = S_READ;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_TEST;
			end
			S_TEST: begin
				cmd.adv = 1'b1;
				if (sts.nonzero) begin
					cmd.emit_found = 1'b1;
					state_nxt      = S_EMIT;
				end else begin
					state_nxt = S_STEP;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== hdl/dtsc_dpath.sv =====
// scan datapath: extents, size check, cursors, address arithmetic, store, result
`timescale 1ns / 1ps
module dtsc_dpath #(
	parameter int unsigned STORE_DEPTH = 4096,
	parameter int unsigned EXTENT_MAX  = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [dtsc_pkg::IDX_W-1:0]      in_index,
	input  logic [dtsc_pkg::VAL_W-1:0]      in_value,
	input  logic                            cfg_we,
	input  logic [dtsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dtsc_pkg::EXT_W-1:0]      cfg_val,
	input  logic                            out_ready,
	output logic                            out_valid,
	output dtsc_pkg::dtsc_res_t             res,
	input  dtsc_pkg::dtsc_cmd_t             cmd,
	output dtsc_pkg::dtsc_sts_t             sts
);

	localparam int EW     = dtsc_pkg::EXT_W;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int MW     = ADDR_W + EW + 1;

	logic [EW-1:0] ext_q [4];

	logic [2*EW-1:0]                 p1_q;
	logic [3*EW-1:0]                 p2_q;
	logic [dtsc_pkg::PROD_W-1:0]     p3_q;
	logic                            size_err_q;
	logic [dtsc_pkg::SETTLE_W-1:0]   settle_q;
	logic                            ext_over;

	logic [EW-1:0]              cur_a_q, cur_b_q, cur_c_q, cur_d_q;
	logic [dtsc_pkg::CNT_W-1:0] count_q;
	logic                       fin_q;

	logic [EW:0]   inc_b, inc_c, inc_d;
	logic [EW-1:0] nxt_a, nxt_b, nxt_c, nxt_d;

	logic [2*EW:0]       t1_full;
	logic [MW-1:0]       t2_full;
	logic [MW-1:0]       addr_full;
	logic [ADDR_W-1:0]   t1_q, t2_q, addr_q;

	logic [dtsc_pkg::VAL_W-1:0] rd_data;
	logic                       wr_ok;

	dtsc_pkg::dtsc_res_t res_q;
	dtsc_pkg::dtsc_res_t out_q;
	logic                out_valid_q;

	// extent registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q[0] <= EW'(1);
			ext_q[1] <= EW'(1);
			ext_q[2] <= EW'(1);
			ext_q[3] <= EW'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				dtsc_pkg::CFG_FIRST_EXTENT:  ext_q[0] <= cfg_val;
				dtsc_pkg::CFG_SECOND_EXTENT: ext_q[1] <= cfg_val;
				dtsc_pkg::CFG_THIRD_EXTENT:  ext_q[2] <= cfg_val;
				dtsc_pkg::CFG_FOURTH_EXTENT: ext_q[3] <= cfg_val;
				default: ;
			endcase
		end
	end

	// size check, one multiply per register stage
	assign ext_over = (32'(ext_q[0]) > 32'(EXTENT_MAX)) || (32'(ext_q[1]) > 32'(EXTENT_MAX)) ||
	                  (32'(ext_q[2]) > 32'(EXTENT_MAX)) || (32'(ext_q[3]) > 32'(EXTENT_MAX));

	always_ff @(posedge clk) begin
		p1_q       <= (2*EW)'(ext_q[0]) * (2*EW)'(ext_q[1]);
		p2_q       <= (3*EW)'(p1_q) * (3*EW)'(ext_q[2]);
		p3_q       <= dtsc_pkg::PROD_W'(p2_q) * dtsc_pkg::PROD_W'(ext_q[3]);
		size_err_q <= ext_over || (p3_q > dtsc_pkg::PROD_W'(STORE_DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= dtsc_pkg::SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= dtsc_pkg::SETTLE_CYCLES;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// cursor advance, fourth index innermost
	always_comb begin
		inc_d = {1'b0, cur_d_q} + 1'b1;
		inc_c = {1'b0, cur_c_q} + 1'b1;
		inc_b = {1'b0, cur_b_q} + 1'b1;
		nxt_a = cur_a_q;
		nxt_b = cur_b_q;
		nxt_c = cur_c_q;
		nxt_d = inc_d[EW-1:0];
		if (inc_d >= {1'b0, ext_q[3]}) begin
			nxt_d = '0;
			nxt_c = inc_c[EW-1:0];
			if (inc_c >= {1'b0, ext_q[2]}) begin
				nxt_c = '0;
				nxt_b = inc_b[EW-1:0];
				if (inc_b >= {1'b0, ext_q[1]}) begin
					nxt_b = '0;
					nxt_a = cur_a_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_a_q <= '0;
			cur_b_q <= '0;
			cur_c_q <= '0;
			cur_d_q <= '0;
			count_q <= '0;
			fin_q   <= 1'b0;
		end else if (cmd.rewind) begin
			cur_a_q <= '0;
			cur_b_q <= '0;
			cur_c_q <= '0;
			cur_d_q <= '0;
			count_q <= '0;
			fin_q   <= 1'b0;
		end else begin
			if (cmd.adv) begin
				cur_a_q <= nxt_a;
				cur_b_q <= nxt_b;
				cur_c_q <= nxt_c;
				cur_d_q <= nxt_d;
			end
			if (cmd.emit_found) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.emit_done) begin
				fin_q <= 1'b1;
			end
		end
	end

	// linear address a + e0*(b + e1*(c + e2*d)), one multiply per cycle;
	// in range it stays below the extent product, so it fits the store
	assign t1_full   = (2*EW+1)'(cur_c_q) + (2*EW+1)'(ext_q[2]) * (2*EW+1)'(cur_d_q);
	assign t2_full   = MW'(cur_b_q) + MW'(ext_q[1]) * MW'(t1_q);
	assign addr_full = MW'(cur_a_q) + MW'(ext_q[0]) * MW'(t2_q);

	always_ff @(posedge clk) begin
		if (cmd.t1_ld) begin
			t1_q <= ADDR_W'(t1_full);
		end
		if (cmd.t2_ld) begin
			t2_q <= ADDR_W'(t2_full);
		end
		if (cmd.addr_ld) begin
			addr_q <= ADDR_W'(addr_full);
		end
	end

	assign wr_ok = cmd.wr_en && (32'(in_index) < 32'(STORE_DEPTH));

	dtsc_ram #(
		.WIDTH (dtsc_pkg::VAL_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_ok),
		.wr_addr (ADDR_W'(in_index)),
		.wr_data (in_value),
		.rd_en   (cmd.rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	// pending result, then the output register
	always_ff @(posedge clk) begin
		if (cmd.emit_found) begin
			res_q.size_error   <= 1'b0;
			res_q.scan_done    <= 1'b0;
			res_q.entry_number <= count_q;
			res_q.found_value  <= rd_data;
			res_q.fourth_coord <= dtsc_pkg::COORD_W'(cur_d_q);
			res_q.third_coord  <= dtsc_pkg::COORD_W'(cur_c_q);
			res_q.second_coord <= dtsc_pkg::COORD_W'(cur_b_q);
			res_q.first_coord  <= dtsc_pkg::COORD_W'(cur_a_q);
		end else if (cmd.emit_done) begin
			res_q.size_error   <= 1'b0;
			res_q.scan_done    <= 1'b1;
			res_q.entry_number <= count_q;
			res_q.found_value  <= '0;
			res_q.fourth_coord <= '0;
			res_q.third_coord  <= '0;
			res_q.second_coord <= '0;
			res_q.first_coord  <= '0;
		end else if (cmd.emit_err) begin
			res_q.size_error   <= 1'b1;
			res_q.scan_done    <= 1'b0;
			res_q.entry_number <= '0;
			res_q.found_value  <= '0;
			res_q.fourth_coord <= '0;
			res_q.third_coord  <= '0;
			res_q.second_coord <= '0;
			res_q.first_coord  <= '0;
		end
		if (cmd.out_ld) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;

	assign sts.stable    = (settle_q == '0);
	assign sts.size_err  = size_err_q;
	assign sts.finished  = fin_q;
	assign sts.first_out = (cur_a_q >= ext_q[0]);
	assign sts.in_range  = (cur_b_q < ext_q[1]) && (cur_c_q < ext_q[2]) && (cur_d_q < ext_q[3]);
	assign sts.nonzero   = (rd_data[dtsc_pkg::VAL_W-2:0] != '0);
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

// ===== test/dense_to_sparse_coordinate_scan_core_tb.sv =====
// self-checking regression bench for the dense-to-sparse coordinate scan core
`timescale 1ns / 1ps
module dense_to_sparse_coordinate_scan_core_tb;

	localparam int unsigned STORE_CELLS  = 4096;
	localparam int unsigned EXTENT_LIMIT = 256;
	localparam int          ITEM_GOAL    = 1900;
	localparam int          STALL_LIMIT  = 100000;
	localparam int          HOLD_CYCLES  = 300;

	localparam logic [dtsc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [dtsc_pkg::CFG_IDX_W-1:0] EXT_REG [4] = '{dtsc_pkg::CFG_FIRST_EXTENT,
		dtsc_pkg::CFG_SECOND_EXTENT, dtsc_pkg::CFG_THIRD_EXTENT, dtsc_pkg::CFG_FOURTH_EXTENT};

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [79:0]                    s_tdata;
	logic [dtsc_pkg::OP_W-1:0]      s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [111:0]                   m_tdata;
	logic [1:0]                     m_tuser;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [dtsc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dtsc_pkg::EXT_W-1:0]     cfg_data;

	dense_to_sparse_coordinate_scan_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// directed stimulus row: either an extent setting or one item
	typedef struct packed {
		bit                                  set_ext;
		logic [3:0][dtsc_pkg::EXT_W-1:0]     ext;
		logic [dtsc_pkg::OP_W-1:0]           op;
		logic [dtsc_pkg::IDX_W-1:0]          idx;
		logic [dtsc_pkg::VAL_W-1:0]          val;
		bit                                  typed;
		dtsc_pkg::dtsc_res_t                 res;
	} plan_row_t;

	plan_row_t plan_q[$];

	// scan shadow state
	logic [dtsc_pkg::VAL_W-1:0] array_shadow [STORE_CELLS];
	bit                         written [STORE_CELLS];
	int unsigned                init_prefix;
	logic [dtsc_pkg::EXT_W-1:0] ext_shadow [4];
	int unsigned                pos_a, pos_b, pos_c, pos_d;
	logic [dtsc_pkg::CNT_W-1:0] found_total;
	bit                         scan_over;

	dtsc_pkg::dtsc_res_t pending_results[$];

	bit idle_on;
	bit hold_req;
	int mismatches;
	int writes_sent, rewinds_sent, fetches_sent, unused_sent, settings_made;
	int found_seen, done_seen, sizeerr_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int items_sent();
		return writes_sent + rewinds_sent + fetches_sent + unused_sent;
	endfunction

	function automatic dtsc_pkg::dtsc_res_t make_res(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d, input logic [dtsc_pkg::VAL_W-1:0] v,
		input logic [dtsc_pkg::CNT_W-1:0] n, input logic done, input logic err);
		dtsc_pkg::dtsc_res_t r;
		r.first_coord  = a;
		r.second_coord = b;
		r.third_coord  = c;
		r.fourth_coord = d;
		r.found_value  = v;
		r.entry_number = n;
		r.scan_done    = done;
		r.size_error   = err;
		return r;
	endfunction

	function automatic void step_cursor();
		pos_d++;
		if (pos_d >= ext_shadow[3]) begin
			pos_d = 0;
			pos_c++;
			if (pos_c >= ext_shadow[2]) begin
				pos_c = 0;
				pos_b++;
				if (pos_b >= ext_shadow[1]) begin
					pos_b = 0;
					pos_a++;
				end
			end
		end
	endfunction

	// walks the cursor to the next nonzero element and returns what a fetch reports, or a size error without walking
	function automatic dtsc_pkg::dtsc_res_t next_nonzero();
		dtsc_pkg::dtsc_res_t        r;
		longint unsigned            cells;
		int unsigned                addr;
		logic [dtsc_pkg::VAL_W-1:0] word;
		r = '0;
		cells = ext_shadow[0];
		for (int k = 1; k < 4; k++)
			cells = cells * ext_shadow[k];
		for (int k = 0; k < 4; k++)
			if (ext_shadow[k] > EXTENT_LIMIT)
				r.size_error = 1'b1;
		if (cells > STORE_CELLS)
			r.size_error = 1'b1;
		if (r.size_error)
			return r;
		while (!scan_over && pos_a < ext_shadow[0]) begin
			if (pos_b < ext_shadow[1] && pos_c < ext_shadow[2] && pos_d < ext_shadow[3]) begin
				addr = pos_a + ext_shadow[0] * (pos_b + ext_shadow[1] *
					(pos_c + ext_shadow[2] * pos_d));
				word = (addr < STORE_CELLS) ? array_shadow[addr] : '0;
				// sign bit alone is minus zero
				if (word[dtsc_pkg::VAL_W-2:0] != '0) begin
					r = make_res(pos_a[7:0], pos_b[7:0], pos_c[7:0], pos_d[7:0], word,
						found_total, 1'b0, 1'b0);
					found_total = found_total + 1'b1;
					step_cursor();
					return r;
				end
			end
			step_cursor();
		end
		scan_over = 1'b1;
		r.scan_done = 1'b1;
		r.entry_number = found_total;
		return r;
	endfunction

	function automatic logic [dtsc_pkg::VAL_W-1:0] pick_word(input int unsigned sparsity);
		if ($urandom_range(0, sparsity) != 0)
			return ($urandom_range(0, 1) != 0) ? 64'h8000_0000_0000_0000 : 64'h0;
		case ($urandom_range(0, 6))
			0: return 64'h0;
			1: return 64'h8000_0000_0000_0000;
			2: return '1;
			3: return 64'h7FF8_0000_0000_0000;
			4: return 64'h1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void plan_extents(input logic [dtsc_pkg::EXT_W-1:0] e0,
		input logic [dtsc_pkg::EXT_W-1:0] e1, input logic [dtsc_pkg::EXT_W-1:0] e2,
		input logic [dtsc_pkg::EXT_W-1:0] e3);
		plan_row_t row;
		row = '0;
		row.set_ext = 1'b1;
		row.ext = {e3, e2, e1, e0};
		plan_q.push_back(row);
	endfunction

	function automatic void plan_item(input logic [dtsc_pkg::OP_W-1:0] op,
		input logic [dtsc_pkg::IDX_W-1:0] idx, input logic [dtsc_pkg::VAL_W-1:0] val,
		input bit typed = 1'b0, input dtsc_pkg::dtsc_res_t res = '0);
		plan_row_t row;
		row = '0;
		row.op = op;
		row.idx = idx;
		row.val = val;
		row.typed = typed;
		row.res = res;
		plan_q.push_back(row);
	endfunction

	function automatic void check_field(input string name,
		input logic [dtsc_pkg::VAL_W-1:0] want, input logic [dtsc_pkg::VAL_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_item(input logic [dtsc_pkg::OP_W-1:0] op,
		input logic [dtsc_pkg::IDX_W-1:0] idx, input logic [dtsc_pkg::VAL_W-1:0] val,
		input bit typed = 1'b0, input dtsc_pkg::dtsc_res_t fixed = '0);
		bit                  hit;
		dtsc_pkg::dtsc_res_t guess;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, val, idx};
		do begin
			@(negedge clk);
			hit = s_tready;
			@(posedge clk);
		end while (!hit);
		case (op)
			dtsc_pkg::OP_WRITE: begin
				array_shadow[idx] = val;
				written[idx] = 1'b1;
				while (init_prefix < STORE_CELLS && written[init_prefix])
					init_prefix++;
				writes_sent++;
			end
			dtsc_pkg::OP_REWIND: begin
				pos_a = 0;
				pos_b = 0;
				pos_c = 0;
				pos_d = 0;
				found_total = '0;
				scan_over = 1'b0;
				rewinds_sent++;
			end
			dtsc_pkg::OP_NEXT: begin
				guess = next_nonzero();
				pending_results.push_back(typed ? fixed : guess);
				fetches_sent++;
			end
			default: unused_sent++;
		endcase
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic set_extents(input logic [dtsc_pkg::EXT_W-1:0] e0,
		input logic [dtsc_pkg::EXT_W-1:0] e1, input logic [dtsc_pkg::EXT_W-1:0] e2,
		input logic [dtsc_pkg::EXT_W-1:0] e3);
		logic [dtsc_pkg::EXT_W-1:0] ev [4];
		bit                         hit;
		ev = '{e0, e1, e2, e3};
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= EXT_REG[k];
			cfg_data  <= ev[k];
			do begin
				@(negedge clk);
				hit = cfg_ready;
				@(posedge clk);
			end while (!hit);
			ext_shadow[k] = ev[k];
		end
		cfg_valid <= 1'b0;
		settings_made++;
		@(posedge clk);
	endtask

	// source stops and waits for every fetch to answer, then lets the core settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_phase(input int phase_no);
		logic [dtsc_pkg::EXT_W-1:0] e [4];
		longint unsigned            cells;
		int unsigned                sparsity, n, lim, dim, pick;
		bit                         usable;
		logic [dtsc_pkg::IDX_W-1:0] idx;
		drain();
		idle_on = (items_sent() < ITEM_GOAL - 300) && ($urandom_range(0, 3) != 0);
		for (int k = 0; k < 4; k++)
			e[k] = dtsc_pkg::EXT_W'($urandom_range(1, 4));
		dim = $urandom_range(0, 3);
		if (phase_no == 8) begin
			e = '{9'd8, 9'd8, 9'd8, 9'd1};
		end else begin
			case ($urandom_range(0, 19))
				0: begin
					e = '{9'd1, 9'd1, 9'd1, 9'd1};
					e[dim] = dtsc_pkg::EXT_W'(EXTENT_LIMIT);
				end
				1: e[dim] = dtsc_pkg::EXT_W'($urandom_range(EXTENT_LIMIT + 1, 511));
				2: begin
					e[dim] = dtsc_pkg::EXT_W'($urandom_range(65, 256));
					e[(dim + 1) % 4] = dtsc_pkg::EXT_W'($urandom_range(64, 256));
				end
				3: e[dim] = '0;
				4: begin
					if (init_prefix == STORE_CELLS) begin
						if ($urandom_range(0, 1) != 0)
							e = '{9'd8, 9'd8, 9'd8, 9'd8};
						else
							e = '{9'd1, 9'd1, 9'd16, 9'd256};
					end
				end
				default: ;
			endcase
		end
		set_extents(e[0], e[1], e[2], e[3]);
		// now and then the cursor is carried over from the previous extents
		if ($urandom_range(0, 9) != 0)
			send_item(dtsc_pkg::OP_REWIND, dtsc_pkg::IDX_W'($urandom), {$urandom, $urandom});
		cells = e[0];
		usable = 1'b1;
		for (int k = 1; k < 4; k++)
			cells = cells * e[k];
		for (int k = 0; k < 4; k++)
			if (e[k] > EXTENT_LIMIT)
				usable = 1'b0;
		if (cells > STORE_CELLS)
			usable = 1'b0;
		sparsity = (phase_no == 8) ? 31 : $urandom_range(0, 7);
		// every element the scan can reach must hold a written value
		if (usable)
			for (int unsigned a = 0; a < cells; a++)
				if (!written[a])
					send_item(dtsc_pkg::OP_WRITE, a[dtsc_pkg::IDX_W-1:0], pick_word(sparsity));
		if (phase_no == 5) begin
			hold_req = 1'b1;
			repeat (12)
				send_item(dtsc_pkg::OP_NEXT, dtsc_pkg::IDX_W'($urandom), {$urandom, $urandom});
		end
		lim = (usable && cells > 0) ? 32'(cells) : STORE_CELLS;
		n = $urandom_range(20, 60);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			idx = dtsc_pkg::IDX_W'(($urandom_range(0, 4) == 0) ?
				$urandom_range(0, STORE_CELLS - 1) : $urandom_range(0, lim - 1));
			if (pick < 55)
				send_item(dtsc_pkg::OP_NEXT, dtsc_pkg::IDX_W'($urandom), {$urandom, $urandom});
			else if (pick < 85)
				send_item(dtsc_pkg::OP_WRITE, idx, pick_word(sparsity));
			else if (pick < 93)
				send_item(dtsc_pkg::OP_REWIND, dtsc_pkg::IDX_W'($urandom),
					{$urandom, $urandom});
			else
				send_item(OP_UNUSED, dtsc_pkg::IDX_W'($urandom), {$urandom, $urandom});
		end
	endtask

	// receiver: random stalls, one long hold-off on request
	initial begin : sink
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// handshakes are sampled on the falling edge ahead of the rising edge that takes them
	always @(negedge clk) begin : result_check
		dtsc_pkg::dtsc_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result item with no fetch waiting");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("first_coord", dtsc_pkg::VAL_W'(want.first_coord),
					dtsc_pkg::VAL_W'(m_tdata[0 +: dtsc_pkg::COORD_W]));
				check_field("second_coord", dtsc_pkg::VAL_W'(want.second_coord),
					dtsc_pkg::VAL_W'(m_tdata[dtsc_pkg::COORD_W +: dtsc_pkg::COORD_W]));
				check_field("third_coord", dtsc_pkg::VAL_W'(want.third_coord),
					dtsc_pkg::VAL_W'(m_tdata[2*dtsc_pkg::COORD_W +: dtsc_pkg::COORD_W]));
				check_field("fourth_coord", dtsc_pkg::VAL_W'(want.fourth_coord),
					dtsc_pkg::VAL_W'(m_tdata[3*dtsc_pkg::COORD_W +: dtsc_pkg::COORD_W]));
				check_field("found_value", want.found_value,
					m_tdata[4*dtsc_pkg::COORD_W +: dtsc_pkg::VAL_W]);
				check_field("entry_number", dtsc_pkg::VAL_W'(want.entry_number),
					dtsc_pkg::VAL_W'(m_tdata[4*dtsc_pkg::COORD_W+dtsc_pkg::VAL_W +:
					dtsc_pkg::CNT_W]));
				check_field("scan_done", dtsc_pkg::VAL_W'(want.scan_done),
					dtsc_pkg::VAL_W'(m_tuser[0]));
				check_field("size_error", dtsc_pkg::VAL_W'(want.size_error),
					dtsc_pkg::VAL_W'(m_tuser[1]));
			end
			if (m_tuser[1])
				sizeerr_seen++;
			else if (m_tuser[0])
				done_seen++;
			else
				found_seen++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("dense_to_sparse_coordinate_scan_core regression: fail");
		$finish;
	end

	initial begin : stimulus
		int phase_no;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= dtsc_pkg::OP_WRITE;
		cfg_valid <= 1'b0;
		cfg_index <= dtsc_pkg::CFG_FIRST_EXTENT;
		cfg_data  <= '0;
		for (int k = 0; k < 4; k++)
			ext_shadow[k] = dtsc_pkg::EXT_W'(1);
		pos_a = 0;
		pos_b = 0;
		pos_c = 0;
		pos_d = 0;
		found_total = '0;
		scan_over = 1'b0;
		init_prefix = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;

		plan_item(OP_UNUSED, 12'hFFF, '1);
		// empty array: done at once, and again
		plan_extents(0, 1, 1, 1);
		plan_item(dtsc_pkg::OP_NEXT, 12'h000, 64'h0, 1'b1,
			make_res(0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
		plan_item(dtsc_pkg::OP_NEXT, 12'hABC, '1, 1'b1, make_res(0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
		plan_extents(257, 1, 1, 1);
		plan_item(dtsc_pkg::OP_NEXT, 12'h000, 64'h0, 1'b1,
			make_res(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
		plan_extents(511, 511, 511, 511);
		plan_item(dtsc_pkg::OP_NEXT, 12'hFFF, '1, 1'b1, make_res(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
		// 4160 elements, one more row than the store holds
		plan_extents(65, 8, 8, 1);
		plan_item(dtsc_pkg::OP_NEXT, 12'h555, 64'h0, 1'b1,
			make_res(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
		plan_item(dtsc_pkg::OP_REWIND, 12'h000, 64'h0);
		plan_item(dtsc_pkg::OP_WRITE, 12'd0, 64'h0);
		plan_item(dtsc_pkg::OP_WRITE, 12'd1, 64'h8000_0000_0000_0000);
		plan_item(dtsc_pkg::OP_WRITE, 12'd2, 64'h7FF8_0000_0000_0000);
		plan_item(dtsc_pkg::OP_WRITE, 12'd3, '1);
		plan_item(dtsc_pkg::OP_WRITE, 12'hFFF, 64'h1);
		plan_extents(4, 1, 1, 1);
		plan_item(dtsc_pkg::OP_NEXT, 12'h000, 64'h0, 1'b1,
			make_res(2, 0, 0, 0, 64'h7FF8_0000_0000_0000, 0, 1'b0, 1'b0));
		plan_item(dtsc_pkg::OP_NEXT, 12'h000, 64'h0, 1'b1,
			make_res(3, 0, 0, 0, '1, 1, 1'b0, 1'b0));
		plan_item(dtsc_pkg::OP_NEXT, 12'h000, 64'h0, 1'b1,
			make_res(0, 0, 0, 0, 0, 2, 1'b1, 1'b0));
		plan_item(dtsc_pkg::OP_NEXT, 12'h000, 64'h0, 1'b1,
			make_res(0, 0, 0, 0, 0, 2, 1'b1, 1'b0));
		plan_item(dtsc_pkg::OP_REWIND, 12'h000, 64'h0);
		plan_item(dtsc_pkg::OP_NEXT, 12'h000, 64'h0);
		// shape changes with the cursor in the middle of a scan
		plan_extents(2, 2, 1, 1);
		plan_item(dtsc_pkg::OP_NEXT, 12'h000, 64'h0);
		plan_item(dtsc_pkg::OP_REWIND, 12'h000, 64'h0);
		plan_item(dtsc_pkg::OP_NEXT, 12'h000, 64'h0);
		plan_item(dtsc_pkg::OP_NEXT, 12'h000, 64'h0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_q[i]) begin
			if (plan_q[i].set_ext) begin
				drain();
				set_extents(plan_q[i].ext[0], plan_q[i].ext[1], plan_q[i].ext[2],
					plan_q[i].ext[3]);
			end else begin
				send_item(plan_q[i].op, plan_q[i].idx, plan_q[i].val, plan_q[i].typed,
					plan_q[i].res);
			end
		end

		phase_no = 0;
		while (items_sent() < ITEM_GOAL) begin
			random_phase(phase_no);
			phase_no++;
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d writes, %0d rewinds, %0d fetches, %0d unused opcodes, %0d shapes",
			writes_sent, rewinds_sent, fetches_sent, unused_sent, settings_made);
		$display("fetch answers: %0d nonzero entries, %0d end of scan, %0d size errors",
			found_seen, done_seen, sizeerr_seen);
		if (mismatches == 0)
			$display("dense_to_sparse_coordinate_scan_core regression: pass");
		else
			$display("dense_to_sparse_coordinate_scan_core regression: fail");
		$finish;
	end

endmodule
